@@ design/cmf_pkg.sv @@
package cmf_pkg;

    // Payload widths of the channels
    localparam int PIX_W      = 8;
    localparam int OUT_COL_W  = 11;
    localparam int OUT_ROW_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register widths
    localparam int HSIZE_W = 12;
    localparam int VSIZE_W = 13;

    // Pixel values for set and clear
    localparam logic [PIX_W-1:0] PIX_SET   = 8'd255;
    localparam logic [PIX_W-1:0] PIX_CLEAR = 8'd0;

    // Result queue geometry (depth must be a power of two)
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_REGION_LEFT   = 3'd2,
        REG_REGION_TOP    = 3'd3,
        REG_REGION_RIGHT  = 3'd4,
        REG_REGION_BOTTOM = 3'd5,
        REG_OPERATION     = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_DILATE = 1'b0,
        OP_ERODE  = 1'b1
    } op_t;

    typedef struct packed {
        logic [HSIZE_W-1:0] image_width;
        logic [VSIZE_W-1:0] image_height;
        logic [HSIZE_W-1:0] region_left;
        logic [VSIZE_W-1:0] region_top;
        logic [HSIZE_W-1:0] region_right;
        logic [VSIZE_W-1:0] region_bottom;
        op_t                operation;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        image_width:   12'd640,
        image_height:  13'd480,
        region_left:   12'd0,
        region_top:    13'd0,
        region_right:  12'd640,
        region_bottom: 13'd480,
        operation:     OP_DILATE
    };

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 last_of_run;
        logic                 frame_end;
    } res_t;

    // Results leaving the window stage in one cycle
    typedef struct packed {
        logic push_a;
        logic push_b;
        res_t res_a;
        res_t res_b;
    } push_t;

endpackage

@@ design/cmf_pix_if.sv @@
interface cmf_pix_if;
    logic                        valid;
    logic                        ready;
    logic [cmf_pkg::PIX_W-1:0]   pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
    modport mon    (input valid, input ready, input pixel_in);
endinterface

@@ design/cmf_res_if.sv @@
interface cmf_res_if;
    logic                            valid;
    logic                            ready;
    logic [cmf_pkg::PIX_W-1:0]       pixel_out;
    logic [cmf_pkg::OUT_COL_W-1:0]   out_col;
    logic [cmf_pkg::OUT_ROW_W-1:0]   out_row;
    logic                            last_of_run;
    logic                            frame_end;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output last_of_run, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input last_of_run, input frame_end, output ready);
    modport mon    (input valid, input ready, input pixel_out, input out_col,
                    input out_row, input last_of_run, input frame_end);
endinterface

@@ design/cmf_cfg_if.sv @@
interface cmf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cmf_pkg::CFG_IDX_W-1:0]     index;
    logic [cmf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/cmf_ram.sv @@
module cmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/cmf_cfg_regs.sv @@
module cmf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cmf_pkg::CFG_DATA_W-1:0]   wr_data,
    output cmf_pkg::cfg_t                    settings
);

    cmf_pkg::cfg_t     cfg_reg;
    cmf_pkg::cfg_t     cfg_next;
    cmf_pkg::cfg_reg_t sel;

    assign sel = cmf_pkg::cfg_reg_t'(wr_index);

    // Decode the register index and update one field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                cmf_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width = wr_data[cmf_pkg::HSIZE_W-1:0];
                cmf_pkg::REG_IMAGE_HEIGHT:
                    cfg_next.image_height = wr_data[cmf_pkg::VSIZE_W-1:0];
                cmf_pkg::REG_REGION_LEFT:
                    cfg_next.region_left = wr_data[cmf_pkg::HSIZE_W-1:0];
                cmf_pkg::REG_REGION_TOP:
                    cfg_next.region_top = wr_data[cmf_pkg::VSIZE_W-1:0];
                cmf_pkg::REG_REGION_RIGHT:
                    cfg_next.region_right = wr_data[cmf_pkg::HSIZE_W-1:0];
                cmf_pkg::REG_REGION_BOTTOM:
                    cfg_next.region_bottom = wr_data[cmf_pkg::VSIZE_W-1:0];
                cmf_pkg::REG_OPERATION:
                    cfg_next.operation = cmf_pkg::op_t'(wr_data[0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cmf_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign settings = cfg_reg;

endmodule

@@ design/cmf_window.sv @@
module cmf_window #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmf_pkg::cfg_t                 settings,
    input  logic                          take,
    input  logic [cmf_pkg::PIX_W-1:0]     pixel,
    output cmf_pkg::push_t                push
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SW    = COL_W + 1;
    localparam int SH    = ROW_W + 1;
    localparam int PW    = cmf_pkg::PIX_W;

    // Effective frame size
    logic [SW-1:0] w;
    logic [SH-1:0] h;

    // Position of the item being accepted
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             col_wrap;
    logic [SH-1:0]    y_pre;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [ROW_W-1:0] py;
    logic [SW-1:0]    x1;
    logic [SH-1:0]    y1;
    logic             has_a;
    logic             has_b;
    logic             fend;
    logic             inner;

    // Window stage registers
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_x_reg;
    logic [ROW_W-1:0] s1_y_reg;
    logic [PW-1:0]    s1_pix_reg;
    logic             s1_has_a_reg;
    logic             s1_has_b_reg;
    logic             s1_fend_reg;
    logic             s1_inner_reg;
    logic             fwd_reg;
    logic [PW-1:0]    fwd_pix_reg;
    logic [PW-1:0]    prev_centre_reg;

    // Neighbourhood
    logic [PW-1:0]    centre;
    logic [PW-1:0]    right;
    logic [PW-1:0]    up_ram;
    logic [PW-1:0]    up;
    logic [PW-1:0]    left;
    logic             any_set;
    logic             any_clear;
    logic [PW-1:0]    val;
    logic [ROW_W-1:0] s1_py;

    // Clamp the configured size to one and to the maximum
    always_comb
    begin
        if (settings.image_width == '0)
        begin
            w = SW'(1);
        end
        else if (32'(settings.image_width) > 32'(MAX_WIDTH))
        begin
            w = SW'(MAX_WIDTH);
        end
        else
        begin
            w = SW'(settings.image_width);
        end

        if (settings.image_height == '0)
        begin
            h = SH'(1);
        end
        else if (32'(settings.image_height) > 32'(MAX_HEIGHT))
        begin
            h = SH'(MAX_HEIGHT);
        end
        else
        begin
            h = SH'(settings.image_height);
        end
    end

    // Wrap a stale position, then work out the next one
    always_comb
    begin
        col_wrap = {1'b0, col_reg} >= w;
        x        = col_wrap ? '0 : col_reg;
        y_pre    = col_wrap ? ({1'b0, row_reg} + SH'(1)) : {1'b0, row_reg};
        y        = (y_pre >= h) ? '0 : y_pre[ROW_W-1:0];
        x1       = {1'b0, x} + SW'(1);
        y1       = {1'b0, y} + SH'(1);
        py       = y - ROW_W'(1);

        if (x1 >= w)
        begin
            col_next = '0;
            row_next = (y1 >= h) ? '0 : y1[ROW_W-1:0];
        end
        else
        begin
            col_next = x1[COL_W-1:0];
            row_next = y;
        end

        has_a = y != '0;
        has_b = y1 == h;
        fend  = x1 == w;
        inner = has_a && (py != '0) && (32'(py) + 32'd2 <= 32'(h))
                && (x != '0) && (32'(x) + 32'd2 <= 32'(w))
                && (32'(py) > 32'(settings.region_top))
                && (32'(py) + 32'd1 < 32'(settings.region_bottom))
                && (32'(x) > 32'(settings.region_left))
                && (32'(x) + 32'd1 < 32'(settings.region_right));
    end

    // Row above: two copies, one read at the centre column, one at the right
    cmf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_above_c (
        .clk   (clk),
        .we    (take),
        .waddr (x),
        .wdata (pixel),
        .re    (take),
        .raddr (x),
        .rdata (centre)
    );

    cmf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_above_r (
        .clk   (clk),
        .we    (take),
        .waddr (x),
        .wdata (pixel),
        .re    (take),
        .raddr (x1[COL_W-1:0]),
        .rdata (right)
    );

    // Row two above, refreshed from the old row above in the cycle after it is read
    cmf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_two (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_x_reg),
        .wdata (centre),
        .re    (take),
        .raddr (x),
        .rdata (up_ram)
    );

    // Advance the position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                fwd_reg <= s1_valid_reg && (s1_x_reg == x);
            end
        end
    end

    // Hold the item's payload for the window stage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_x_reg     <= x;
            s1_y_reg     <= y;
            s1_pix_reg   <= pixel;
            s1_has_a_reg <= has_a;
            s1_has_b_reg <= has_b;
            s1_fend_reg  <= fend;
            s1_inner_reg <= inner;
            fwd_pix_reg  <= centre;
        end
        if (s1_valid_reg)
        begin
            prev_centre_reg <= centre;
        end
    end

    // Forward the row-two-above write that coincided with the read
    assign up   = fwd_reg ? fwd_pix_reg : up_ram;
    assign left = prev_centre_reg;

    // Apply the cross element
    always_comb
    begin
        any_set   = (centre | up | left | right | s1_pix_reg) != '0;
        any_clear = (centre == '0) || (up == '0) || (left == '0)
                    || (right == '0) || (s1_pix_reg == '0);
        if (!s1_inner_reg)
        begin
            val = centre;
        end
        else if (settings.operation == cmf_pkg::OP_DILATE)
        begin
            val = any_set ? cmf_pkg::PIX_SET : cmf_pkg::PIX_CLEAR;
        end
        else
        begin
            val = any_clear ? cmf_pkg::PIX_CLEAR : cmf_pkg::PIX_SET;
        end
    end

    assign s1_py = s1_y_reg - ROW_W'(1);

    // Build the results of the item in the window stage
    always_comb
    begin
        push.push_a            = s1_valid_reg && s1_has_a_reg;
        push.push_b            = s1_valid_reg && s1_has_b_reg;
        push.res_a.pixel_out   = val;
        push.res_a.out_col     = cmf_pkg::OUT_COL_W'(s1_x_reg);
        push.res_a.out_row     = cmf_pkg::OUT_ROW_W'(s1_py);
        push.res_a.last_of_run = !s1_has_b_reg;
        push.res_a.frame_end   = 1'b0;
        push.res_b.pixel_out   = s1_pix_reg;
        push.res_b.out_col     = cmf_pkg::OUT_COL_W'(s1_x_reg);
        push.res_b.out_row     = cmf_pkg::OUT_ROW_W'(s1_y_reg);
        push.res_b.last_of_run = 1'b1;
        push.res_b.frame_end   = s1_fend_reg;
    end

endmodule

@@ design/cmf_out_fifo.sv @@
module cmf_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  cmf_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output cmf_pkg::res_t    out_data
);

    localparam int PTR_W = cmf_pkg::RES_PTR_W;
    localparam int CNT_W = cmf_pkg::RES_CNT_W;

    cmf_pkg::res_t    slot_reg [cmf_pkg::RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       n_push;
    logic             pop;
    logic [PTR_W-1:0] b_ptr;

    assign n_push    = {1'b0, push.push_a} + {1'b0, push.push_b};
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign b_ptr     = push.push_a ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;

    // Keep space for two results of the item about to enter the window stage
    assign room = (count_reg + CNT_W'(n_push)) <= CNT_W'(cmf_pkg::RES_DEPTH - 2);

    assign count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.push_a)
        begin
            slot_reg[wr_ptr_reg] <= push.res_a;
        end
        if (push.push_b)
        begin
            slot_reg[b_ptr] <= push.res_b;
        end
    end

endmodule

@@ design/cross_morphology_filter_top.sv @@
// Channel   Dir  Handshake     Payload
// pixels    in   valid/ready   pixel_in
// results   out  valid/ready   pixel_out, out_col, out_row, last_of_run, frame_end
// cfg       in   valid/ready   index, data (register write, always ready)
//
// One item per cycle while pixels.ready is high; its results pass the window stage and
// the result queue. The rate is set by the three line memories, each read once per
// item. On the last row each item gives two results, so the single output port limits
// the rate there. rst_n clears the counters, pipeline and result queue; the line
// memories are never cleared. pixels.ready drops while the eight-entry result queue,
// with the results already on their way, would have fewer than two free entries.
module cross_morphology_filter_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    cmf_pix_if.sink           pixels,
    cmf_res_if.source         results,
    cmf_cfg_if.sink           cfg
);

    cmf_pkg::cfg_t  reg_set;
    cmf_pkg::push_t push;
    cmf_pkg::res_t  head;
    logic           room;
    logic           take;

    assign cfg.ready    = 1'b1;
    assign pixels.ready = room;
    assign take         = pixels.valid && room;

    cmf_cfg_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .settings (reg_set)
    );

    cmf_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .settings (reg_set),
        .take     (take),
        .pixel    (pixels.pixel_in),
        .push     (push)
    );

    cmf_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (head)
    );

    assign results.pixel_out   = head.pixel_out;
    assign results.out_col     = head.out_col;
    assign results.out_row     = head.out_row;
    assign results.last_of_run = head.last_of_run;
    assign results.frame_end   = head.frame_end;

endmodule

@@ design/cmf_checker.sv @@
module cmf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_valid,
    input logic                            pix_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [cmf_pkg::PIX_W-1:0]       res_pixel_out,
    input logic [cmf_pkg::OUT_COL_W-1:0]   res_out_col,
    input logic [cmf_pkg::OUT_ROW_W-1:0]   res_out_row,
    input logic                            res_last_of_run,
    input logic                            res_frame_end
);

    // Input stalls only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid)
        else $error("input stalled with no result pending");

    // A result appears only after an item was taken and passed the window stage and result queue registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result appeared without a matching item");

    // On the last row the second result of an item follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last_of_run |=>
            res_valid && res_last_of_run
            && (res_out_col == $past(res_out_col)))
        else $error("second result of an item missing");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_pixel_out) && $stable(res_out_col)
            && $stable(res_out_row) && $stable(res_last_of_run)
            && $stable(res_frame_end))
        else $error("stalled result changed");

endmodule

bind cross_morphology_filter_top cmf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pixels.valid),
    .pix_ready       (pixels.ready),
    .res_valid       (results.valid),
    .res_ready       (results.ready),
    .res_pixel_out   (results.pixel_out),
    .res_out_col     (results.out_col),
    .res_out_row     (results.out_row),
    .res_last_of_run (results.last_of_run),
    .res_frame_end   (results.frame_end)
);
